// ----- sv/rmt_pkg.sv -----
// Shared state codes for the running median tracker.
package rmt_pkg;

    localparam int unsigned STATE_W = 3;
    typedef logic [STATE_W-1:0] t_state;

    localparam t_state ST_IDLE  = 3'd0;
    localparam t_state ST_SHIFT = 3'd1;
    localparam t_state ST_WR0   = 3'd2;
    localparam t_state ST_MHI   = 3'd3;
    localparam t_state ST_MLO   = 3'd4;
    localparam t_state ST_MED   = 3'd5;
    localparam t_state ST_OUT   = 3'd6;

    localparam int unsigned COUNT_OUT_W = 9;

endpackage

// ----- sv/running_median_tracker.sv -----
// Running median tracker: sorted sample store in one memory, insertion walk and median read.
// Each item inserts one signed sample into an ascending store of up to CAPACITY samples
// (a start flag empties it first) and gives the count and twice the median. The store is a
// single-port-write, single-read memory with a registered read; insertion walks down from the
// top, one entry moved per cycle, moving each held sample greater than the new one up one
// place; a sample that comes while the store is full is dropped, not inserted. An item waits
// in the output state while the output register is held by a stall. The next item is taken
// once the previous result has entered the output register.
module running_median_tracker #(
    parameter int unsigned CAPACITY     = 256,
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_start_req,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SAMPLE_WIDTH:0]   o_median_x2,
    output logic [rmt_pkg::COUNT_OUT_W-1:0] o_count,
    output logic                    o_dropped
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [SAMPLE_WIDTH-1:0] mem [CAPACITY];

    rmt_pkg::t_state         r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [AW-1:0]           r_idx, n_idx;
    logic [SAMPLE_WIDTH-1:0] r_sample, n_sample;
    logic                    r_drop, n_drop;
    logic [SAMPLE_WIDTH-1:0] r_rdata;
    logic [SAMPLE_WIDTH-1:0] r_hi, n_hi;
    logic [SAMPLE_WIDTH:0]   r_med, n_med;
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_WIDTH:0]   r_out_med, n_out_med;
    logic [CW-1:0]           r_out_cnt, n_out_cnt;
    logic                    r_out_drop, n_out_drop;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [SAMPLE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [CW-1:0]           cnt_eff;
    logic [CW-1:0]           cnt_half;
    logic [AW-1:0]           hi_addr;

    assign cnt_half = r_cnt >> 1;
    assign hi_addr  = AW'(cnt_half);
    assign cnt_eff  = i_start_req ? '0 : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_sample    = r_sample;
        n_drop      = r_drop;
        n_hi        = r_hi;
        n_med       = r_med;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_med   = r_out_med;
        n_out_cnt   = r_out_cnt;
        n_out_drop  = r_out_drop;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_sample;
        mem_raddr   = hi_addr - AW'(1);
        o_in_stall  = (r_state != rmt_pkg::ST_IDLE);
        case (r_state)
            rmt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_sample;
                    n_drop   = 1'b0;
                    n_cnt    = cnt_eff;
                    if (cnt_eff == CW'(CAPACITY)) begin
                        n_drop  = 1'b1;
                        n_state = rmt_pkg::ST_MHI;
                    end else if (cnt_eff == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = i_sample;
                        n_cnt     = CW'(1);
                        n_state   = rmt_pkg::ST_MHI;
                    end else begin
                        mem_raddr = AW'(cnt_eff - CW'(1));
                        n_idx     = AW'(cnt_eff - CW'(1));
                        n_state   = rmt_pkg::ST_SHIFT;
                    end
                end
            end
            rmt_pkg::ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + AW'(1);
                // move larger entries up one place until the insertion point is found
                if ($signed(r_rdata) > $signed(r_sample)) begin
                    mem_wdata = r_rdata;
                    if (r_idx == '0) begin
                        n_state = rmt_pkg::ST_WR0;
                    end else begin
                        n_idx     = r_idx - AW'(1);
                        mem_raddr = r_idx - AW'(1);
                    end
                end else begin
                    mem_wdata = r_sample;
                    n_cnt     = r_cnt + CW'(1);
                    n_state   = rmt_pkg::ST_MHI;
                end
            end
            rmt_pkg::ST_WR0: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_sample;
                n_cnt     = r_cnt + CW'(1);
                n_state   = rmt_pkg::ST_MHI;
            end
            rmt_pkg::ST_MHI: begin
                mem_raddr = hi_addr;
                n_state   = rmt_pkg::ST_MLO;
            end
            rmt_pkg::ST_MLO: begin
                n_hi    = r_rdata;
                n_state = rmt_pkg::ST_MED;
            end
            rmt_pkg::ST_MED: begin
                if (r_cnt[0]) begin
                    n_med = {r_hi, 1'b0};
                end else begin
                    n_med = {r_hi[SAMPLE_WIDTH-1], r_hi} + {r_rdata[SAMPLE_WIDTH-1], r_rdata};
                end
                n_state = rmt_pkg::ST_OUT;
            end
            rmt_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_med   = r_med;
                    n_out_cnt   = r_cnt;
                    n_out_drop  = r_drop;
                    n_state     = rmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_sample   <= n_sample;
        r_drop     <= n_drop;
        r_hi       <= n_hi;
        r_med      <= n_med;
        r_out_med  <= n_out_med;
        r_out_cnt  <= n_out_cnt;
        r_out_drop <= n_out_drop;
    end

    assign o_out_valid = r_out_valid;
    assign o_median_x2 = r_out_med;
    assign o_count     = rmt_pkg::COUNT_OUT_W'(r_out_cnt);
    assign o_dropped   = r_out_drop;

endmodule
